[rtl/tbpc_pkg.sv]
package tbpc_pkg;

  localparam int TIME_BITS = 32;
  localparam int NOW_W = 32;
  localparam int MS_W = 16;
  localparam int COUNT_W = 5;
  localparam int IDX_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ADV_DEPTH = 1 << (2 * IDX_W);

  localparam logic [MS_W-1:0] LONG_PRESS_RESET = MS_W'(1000);
  localparam logic [MS_W-1:0] DEBOUNCE_RESET = MS_W'(50);
  localparam logic [COUNT_W-1:0] MODE_COUNT_RESET = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] LEVEL_COUNT_RESET = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1 << IDX_W);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LONG_PRESS  = 2'd0,
    REG_DEBOUNCE    = 2'd1,
    REG_MODE_COUNT  = 2'd2,
    REG_LEVEL_COUNT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
    logic             first_pressed;
    logic             second_pressed;
  } in_word_t;

  typedef struct packed {
    logic             lights_off;
    logic [IDX_W-1:0] mode_now;
    logic [IDX_W-1:0] level_now;
    logic             blank_request;
    logic             save_settings;
    logic             save_mode;
  } out_word_t;

  // Next index table, addressed by {current index, effective count - 1}.
  typedef logic [IDX_W-1:0] adv_table_t [ADV_DEPTH];

  function automatic adv_table_t build_adv_table();
    adv_table_t       tbl;
    logic [IDX_W:0]   v;
    logic [IDX_W:0]   n;
    for (int i = 0; i < ADV_DEPTH; i++) begin
      v = (IDX_W + 1)'(i >> IDX_W) + 1'b1;
      n = (IDX_W + 1)'(i & ((1 << IDX_W) - 1)) + 1'b1;
      for (int k = 0; k < (1 << IDX_W); k++) begin
        if (v >= n) begin
          v = v - n;
        end
      end
      tbl[i] = v[IDX_W-1:0];
    end
    return tbl;
  endfunction

  localparam adv_table_t ADV_TABLE = build_adv_table();

  // A count of zero behaves as one and anything above the maximum as the maximum.
  function automatic logic [IDX_W-1:0] count_last(input logic [COUNT_W-1:0] c);
    logic [IDX_W-1:0] r;
    if (c == '0) begin
      r = '0;
    end else if (c > COUNT_MAX) begin
      r = '1;
    end else begin
      r = IDX_W'(c - 1'b1);
    end
    return r;
  endfunction

endpackage

[rtl/two_button_press_classifier.sv]
// Two-button press classifier.
// Input channel (in_valid/in_ready/in_data) carries one poll word per sample:
// a millisecond timestamp and the levels of both buttons. Each accepted word
// yields exactly one result word on the output channel (out_valid/out_ready/
// out_data) with the current LEDs-off flag, mode and brightness indices and
// the blank and save pulses raised by that poll.
// Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) set the long
// press time, debounce time, mode count and level count; cfg_ready is always
// high and writes are expected only while the block is idle.
// A word is held in the input register, then the classification logic updates
// the button state and loads the result register.
// Throughput is one word per cycle while the receiver takes every result; only
// receiver stalls hold it back, not the state update between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; in_ready falls only when both are full.
// Synchronous reset clears both buttons' history, turns the LEDs on, sets both
// indices to zero and restores the default configuration.
module two_button_press_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tbpc_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tbpc_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tbpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tbpc_pkg::*;

  logic [MS_W-1:0]    long_press_r;
  logic [MS_W-1:0]    debounce_r;
  logic [COUNT_W-1:0] mode_count_r;
  logic [COUNT_W-1:0] level_count_r;

  in_word_t           s1_word_r;
  logic               s1_valid_r;
  out_word_t          out_word_r;
  out_word_t          out_word_nxt;
  logic               out_valid_r;

  logic               first_prev_r, first_prev_nxt;
  time_t              first_since_r, first_since_nxt;
  logic               first_fired_r, first_fired_nxt;
  logic               second_prev_r, second_prev_nxt;
  time_t              second_since_r, second_since_nxt;
  logic               off_flag_r, off_flag_nxt;
  logic [IDX_W-1:0]   mode_index_r, mode_index_nxt;
  logic [IDX_W-1:0]   level_index_r, level_index_nxt;

  logic               s1_fire;
  logic               in_fire;
  time_t              now;
  time_t              first_elapsed;
  time_t              second_elapsed;
  logic               p1, p2;
  logic               blank, save_set, save_md;
  logic [IDX_W-1:0]   mode_adv, level_adv;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r  <= LONG_PRESS_RESET;
      debounce_r    <= DEBOUNCE_RESET;
      mode_count_r  <= MODE_COUNT_RESET;
      level_count_r <= LEVEL_COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LONG_PRESS:  long_press_r  <= cfg_data[MS_W-1:0];
        REG_DEBOUNCE:    debounce_r    <= cfg_data[MS_W-1:0];
        REG_MODE_COUNT:  mode_count_r  <= cfg_data[COUNT_W-1:0];
        REG_LEVEL_COUNT: level_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    now            = TIME_BITS'(s1_word_r.now_ms);
    p1             = s1_word_r.first_pressed;
    p2             = s1_word_r.second_pressed;
    first_elapsed  = now - first_since_r;
    second_elapsed = now - second_since_r;
    mode_adv  = ADV_TABLE[{mode_index_r, count_last(mode_count_r)}];
    level_adv = ADV_TABLE[{level_index_r, count_last(level_count_r)}];

    blank           = 1'b0;
    save_set        = 1'b0;
    save_md         = 1'b0;
    first_since_nxt = first_since_r;
    first_fired_nxt = first_fired_r;
    second_since_nxt = second_since_r;
    off_flag_nxt    = off_flag_r;
    mode_index_nxt  = mode_index_r;
    level_index_nxt = level_index_r;

    // A press edge only records its time; the hold is tested from the next poll on.
    priority if (p1 && !first_prev_r) begin
      first_since_nxt = now;
      first_fired_nxt = 1'b0;
    end else if (p1 && first_prev_r && !first_fired_r) begin
      if (first_elapsed >= TIME_BITS'(long_press_r)) begin
        first_fired_nxt = 1'b1;
        if (!off_flag_r) begin
          off_flag_nxt = 1'b1;
          blank        = 1'b1;
          save_set     = 1'b1;
        end
      end
    end else if (!p1 && first_prev_r) begin
      if (!first_fired_r && first_elapsed >= TIME_BITS'(debounce_r)) begin
        if (off_flag_r) begin
          off_flag_nxt = 1'b0;
          save_set     = 1'b1;
        end else begin
          mode_index_nxt = mode_adv;
          save_md        = 1'b1;
        end
      end
    end else begin
    end
    first_prev_nxt = p1;

    priority if (p2 && !second_prev_r) begin
      second_since_nxt = now;
    end else if (!p2 && second_prev_r) begin
      if (second_elapsed >= TIME_BITS'(debounce_r)) begin
        level_index_nxt = level_adv;
        save_set        = 1'b1;
      end
    end else begin
    end
    second_prev_nxt = p2;

    out_word_nxt.lights_off    = off_flag_nxt;
    out_word_nxt.mode_now      = mode_index_nxt;
    out_word_nxt.level_now     = level_index_nxt;
    out_word_nxt.blank_request = blank;
    out_word_nxt.save_settings = save_set;
    out_word_nxt.save_mode     = save_md;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      first_prev_r   <= 1'b0;
      first_since_r  <= '0;
      first_fired_r  <= 1'b0;
      second_prev_r  <= 1'b0;
      second_since_r <= '0;
      off_flag_r     <= 1'b0;
      mode_index_r   <= '0;
      level_index_r  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r    <= 1'b1;
        first_prev_r   <= first_prev_nxt;
        first_since_r  <= first_since_nxt;
        first_fired_r  <= first_fired_nxt;
        second_prev_r  <= second_prev_nxt;
        second_since_r <= second_since_nxt;
        off_flag_r     <= off_flag_nxt;
        mode_index_r   <= mode_index_nxt;
        level_index_r  <= level_index_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_data;
    end
    if (s1_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  // A blank pulse only comes with the LEDs going off, which is also saved.
  a_blank_means_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.blank_request |->
      out_word_r.lights_off && out_word_r.save_settings)
    else $error("blank request without LEDs off and save");

  a_mode_only_when_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.save_mode |->
      !out_word_r.lights_off && !out_word_r.blank_request)
    else $error("mode advanced while LEDs off");

  a_mode_change_saved: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (mode_index_r == $past(mode_index_r)) || out_word_r.save_mode)
    else $error("mode changed without save pulse");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled while a register was free");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tbpc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_POLLS = 105;

  // Mirror of the classifier: button history, settings and the words still owed.
  class press_scoreboard;
    logic [MS_W-1:0]    long_ms;
    logic [MS_W-1:0]    debounce_ms;
    logic [COUNT_W-1:0] mode_cnt;
    logic [COUNT_W-1:0] level_cnt;
    logic               b1_prev;
    logic               b1_fired;
    logic               b2_prev;
    logic [NOW_W-1:0]   b1_since;
    logic [NOW_W-1:0]   b2_since;
    logic               off;
    logic [IDX_W-1:0]   mode;
    logic [IDX_W-1:0]   level;
    out_word_t          owed_q[$];
    int mismatches;
    int checked;
    int n_long;
    int n_on;
    int n_mode;
    int n_level;

    function new();
      long_ms = LONG_PRESS_RESET;
      debounce_ms = DEBOUNCE_RESET;
      mode_cnt = MODE_COUNT_RESET;
      level_cnt = LEVEL_COUNT_RESET;
      b1_prev = 1'b0;
      b1_fired = 1'b0;
      b2_prev = 1'b0;
      b1_since = '0;
      b2_since = '0;
      off = 1'b0;
      mode = '0;
      level = '0;
      mismatches = 0;
      checked = 0;
      n_long = 0;
      n_on = 0;
      n_mode = 0;
      n_level = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_LONG_PRESS:  long_ms = d;
        REG_DEBOUNCE:    debounce_ms = d;
        REG_MODE_COUNT:  mode_cnt = d[COUNT_W-1:0];
        REG_LEVEL_COUNT: level_cnt = d[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // A count of zero cycles through one value and anything past sixteen through sixteen.
    function logic [IDX_W-1:0] next_index(logic [IDX_W-1:0] idx, logic [COUNT_W-1:0] cnt);
      int n;
      n = cnt;
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      return IDX_W'((int'(idx) + 1) % n);
    endfunction

    function void note_poll(in_word_t w);
      out_word_t        e;
      logic [NOW_W-1:0] held1;
      logic [NOW_W-1:0] held2;
      e = '0;
      held1 = w.now_ms - b1_since;
      held2 = w.now_ms - b2_since;
      if (w.first_pressed && !b1_prev) begin
        b1_since = w.now_ms;
        b1_fired = 1'b0;
      end else if (w.first_pressed && !b1_fired) begin
        if (held1 >= long_ms) begin
          b1_fired = 1'b1;
          if (!off) begin
            off = 1'b1;
            e.blank_request = 1'b1;
            e.save_settings = 1'b1;
            n_long++;
          end
        end
      end else if (!w.first_pressed && b1_prev) begin
        if (!b1_fired && held1 >= debounce_ms) begin
          if (off) begin
            off = 1'b0;
            e.save_settings = 1'b1;
            n_on++;
          end else begin
            mode = next_index(mode, mode_cnt);
            e.save_mode = 1'b1;
            n_mode++;
          end
        end
      end
      b1_prev = w.first_pressed;

      if (w.second_pressed && !b2_prev) begin
        b2_since = w.now_ms;
      end else if (!w.second_pressed && b2_prev) begin
        if (held2 >= debounce_ms) begin
          level = next_index(level, level_cnt);
          e.save_settings = 1'b1;
          n_level++;
        end
      end
      b2_prev = w.second_pressed;

      e.lights_off = off;
      e.mode_now = mode;
      e.level_now = level;
      owed_q.push_back(e);
    endfunction

    function string fmt(out_word_t w);
      return $sformatf("off=%0d mode=%0d level=%0d blank=%0d save_set=%0d save_mode=%0d",
                       w.lights_off, w.mode_now, w.level_now, w.blank_request,
                       w.save_settings, w.save_mode);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result word with none owed: %s", fmt(got));
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if (got.lights_off !== e.lights_off || got.mode_now !== e.mode_now ||
          got.level_now !== e.level_now || got.blank_request !== e.blank_request ||
          got.save_settings !== e.save_settings || got.save_mode !== e.save_mode) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result word %0d mismatch", checked);
          $display("  expected %s", fmt(e));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_word_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_word_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LONG_PRESS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  press_scoreboard sb;
  int send_idle_pct = 13;
  int recv_stall_pct = 57;
  int quiet = 0;
  int n_polls = 0;

  // What the random sequences believe about the buttons, so holds can be aimed at thresholds.
  logic             held_a = 1'b0;
  logic             held_b = 1'b0;
  logic [NOW_W-1:0] press_a_t = '0;
  logic [NOW_W-1:0] press_b_t = '0;
  logic [NOW_W-1:0] clock_ms = '0;

  two_button_press_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", quiet);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_poll(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_poll(w);
    n_polls++;
  endtask

  task automatic poll(input logic [NOW_W-1:0] t, input logic a, input logic b);
    in_word_t w;
    w.now_ms = t;
    w.first_pressed = a;
    w.second_pressed = b;
    send_poll(w);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, d);
  endtask

  // Wait for every owed word, then give the two-stage pipe time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    logic [NOW_W-1:0] t;
    logic [NOW_W-1:0] target;
    logic [NOW_W-1:0] thr;
    logic             a;
    logic             b;
    int               k;
    int               dl;
    int               lg;
    for (int i = 0; i < count; i++) begin
      a = held_a;
      b = held_b;
      dl = sb.debounce_ms;
      lg = sb.long_ms;
      k = $urandom_range(99);
      if (k < 8) begin
        t = $urandom();
        a = 1'($urandom_range(1));
        b = 1'($urandom_range(1));
      end else begin
        t = clock_ms + NOW_W'($urandom_range(3));
        if (k < 30 && held_a) begin
          thr = $urandom_range(1) ? NOW_W'(lg) : NOW_W'(dl);
          target = press_a_t + thr + NOW_W'($urandom_range(2)) - 1'b1;
          if (target - clock_ms < 32'h8000_0000) t = target;
        end else if (k < 42 && held_b) begin
          target = press_b_t + NOW_W'(dl) + NOW_W'($urandom_range(2)) - 1'b1;
          if (target - clock_ms < 32'h8000_0000) t = target;
        end else if (k < 70) begin
          t = clock_ms + NOW_W'($urandom_range(dl * 2 + 4));
        end else if (k < 85) begin
          t = clock_ms + NOW_W'($urandom_range(lg * 2 + 4));
        end
        if ($urandom_range(99) < 30) a = !a;
        if ($urandom_range(99) < 25) b = !b;
      end
      if (a && !held_a) press_a_t = t;
      if (b && !held_b) press_b_t = t;
      held_a = a;
      held_b = b;
      clock_ms = t;
      poll(t, a, b);
    end
  endtask

  initial begin
    logic [NOW_W-1:0]      t;
    logic [NOW_W-1:0]      base;
    logic [CFG_DATA_W-1:0] lp;
    logic [CFG_DATA_W-1:0] db;
    logic [CFG_DATA_W-1:0] mc;
    logic [CFG_DATA_W-1:0] lc;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset settings; the timestamps cross the 32-bit wrap.
    base = 32'hFFFF_FC00;
    poll(base, 1'b0, 1'b0);
    poll(base + 32'd10, 1'b1, 1'b0);
    poll(base + 32'd1009, 1'b1, 1'b0);
    poll(base + 32'd1010, 1'b1, 1'b0);
    poll(base + 32'd1500, 1'b0, 1'b0);
    poll(base + 32'd1600, 1'b1, 1'b1);
    poll(base + 32'd1649, 1'b0, 1'b0);
    poll(base + 32'd1700, 1'b1, 1'b1);
    poll(base + 32'd1750, 1'b0, 1'b0);
    t = base + 32'd2000;
    for (int i = 0; i < 4; i++) begin
      poll(t, 1'b1, i < 2);
      poll(t + 32'd60, 1'b0, 1'b0);
      t = t + 32'd100;
    end
    // One long hold turns the lights off; a second while they are off must fire silently.
    poll(t, 1'b1, 1'b0);
    poll(t + 32'd1000, 1'b1, 1'b0);
    poll(t + 32'd1001, 1'b0, 1'b0);
    poll(t + 32'd2000, 1'b1, 1'b0);
    poll(t + 32'd4000, 1'b1, 1'b0);
    poll(t + 32'd4100, 1'b0, 1'b1);
    poll(t + 32'd4200, 1'b0, 1'b0);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin lp = 16'd20;    db = 16'd5;     mc = 16'h0003; lc = 16'h0005; end
        1: begin lp = 16'd0;     db = 16'd0;     mc = 16'h0000; lc = 16'hFFE0; end
        2: begin lp = 16'hFFFF;  db = 16'hFFFF;  mc = 16'hABF0; lc = 16'h0010; end
        3: begin lp = 16'd300;   db = 16'd40;    mc = 16'h001F; lc = 16'hFF11; end
        4: begin lp = 16'd7;     db = 16'd3;     mc = 16'h0002; lc = 16'h0001; end
        default: begin lp = 16'd1000; db = 16'd50; mc = 16'h0004; lc = 16'h0004; end
      endcase
      write_reg(REG_LONG_PRESS, lp);
      write_reg(REG_DEBOUNCE, db);
      write_reg(REG_MODE_COUNT, mc);
      write_reg(REG_LEVEL_COUNT, lc);
      cfg_valid <= 1'b0;
      if (p < 2) begin
        send_idle_pct = 13;
        recv_stall_pct = 57;
      end else if (p < 4) begin
        send_idle_pct = 57;
        recv_stall_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      clock_ms = $urandom();
      run_random(PHASE_POLLS);
    end

    drain();
    repeat (16) @(posedge clk);
    $display("Covered %0d polls across the reset settings and six register settings,",
             n_polls);
    $display("%0d words checked.", sb.checked);
    $display("Events seen: %0d long presses, %0d lights on, %0d mode steps, %0d level steps.",
             sb.n_long, sb.n_on, sb.n_mode, sb.n_level);
    if (sb.pending() != 0) $display("ERROR: %0d result words never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("ERROR: %0d mismatches", sb.mismatches);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
